// ===== hw/rtl/cktt_pkg.sv =====
// Shared types, field layout and constants for the circular kernel theta table.
package cktt_pkg;

   localparam int MAX_SITES_DEF = 64;
   localparam int MAX_TAPS_DEF  = 16;
   localparam int WEIGHT_BITS   = 16;
   localparam int THETA_BITS    = 21;
   localparam int MIN_SITES     = 2;

   // field widths
   localparam int CMD_BITS    = 2;
   localparam int WIDX_BITS   = 4;
   localparam int OCC_BITS    = 64;
   localparam int HSITE_BITS  = 5;
   localparam int SITE_BITS   = 6;
   localparam int SCOUNT_BITS = 7;
   localparam int TCOUNT_BITS = 5;
   localparam int BIAS_BITS   = 16;

   // stream layout
   localparam int REQ_DATA_BITS  = 96;
   localparam int RSP_DATA_BITS  = 32;
   localparam int WIDX_LSB       = 0;
   localparam int WVAL_LSB       = 4;
   localparam int OCC_LSB        = 20;
   localparam int SPIN_LSB       = 84;
   localparam int TO_LSB         = 85;
   localparam int FROM_LSB       = 90;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;

   localparam logic [CMD_BITS-1:0] CMD_WEIGHT = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_LOAD   = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_HOP    = 2'd2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_SITE_COUNT = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TAP_COUNT  = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BIAS       = 2'd2;

   localparam logic [SCOUNT_BITS-1:0]      SITE_COUNT_RST = 7'd64;
   localparam logic [TCOUNT_BITS-1:0]      TAP_COUNT_RST  = 5'd16;
   localparam logic signed [BIAS_BITS-1:0] BIAS_RST       = 16'sd410;  // 0.1 in Q3.12

   typedef enum logic [1:0] {
      OP_WEIGHT,
      OP_LOAD,
      OP_HOP,
      OP_REFRESH
   } op_type;

   typedef struct packed {
      logic [SCOUNT_BITS-1:0]      sites;   // clamped site count
      logic [TCOUNT_BITS-1:0]      taps;
      logic signed [BIAS_BITS-1:0] bias;
   } cfg_type;

   typedef struct packed {
      op_type                        op;
      logic [WIDX_BITS-1:0]          widx;
      logic signed [WEIGHT_BITS-1:0] wval;
      logic [OCC_BITS-1:0]           occ;
      logic [SITE_BITS-1:0]          clr_pos;
      logic [SITE_BITS-1:0]          set_pos;
   } job_type;

endpackage

// ===== hw/rtl/cktt_front.sv =====
// Request decode and the two-entry job queue feeding the sum engine.
module cktt_front #(
   parameter int MAX_TAPS = cktt_pkg::MAX_TAPS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // weight_index, weight_value, occupancy, spin, to_site, from_site, zero pad
   input  logic [cktt_pkg::REQ_DATA_BITS-1:0] req_tdata,
   // cmd
   input  logic [cktt_pkg::CMD_BITS-1:0]      req_tuser,
   input  cktt_pkg::cfg_type                  cfg,
   output logic                               job_valid,
   input  logic                               job_ready,
   output cktt_pkg::job_type                  job
);

   localparam int QD  = 2;
   localparam int QPW = $clog2(QD);
   localparam int QCW = $clog2(QD + 1);

   logic [cktt_pkg::WIDX_BITS-1:0]   widx;
   logic [cktt_pkg::HSITE_BITS-1:0]  to_site;
   logic [cktt_pkg::HSITE_BITS-1:0]  from_site;
   logic                             spin;
   logic [cktt_pkg::SCOUNT_BITS-1:0] half;
   logic [cktt_pkg::SCOUNT_BITS-1:0] offset;
   logic [cktt_pkg::SCOUNT_BITS-1:0] to_pos;
   logic [cktt_pkg::SCOUNT_BITS-1:0] from_pos;
   logic                             hop_ok;
   logic                             keep;
   cktt_pkg::job_type                entry_in;

   cktt_pkg::job_type q_ff [QD];
   logic [QPW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QPW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QCW-1:0]    count_ff, count_in;
   logic              push, pop;

   assign widx      = req_tdata[cktt_pkg::WIDX_LSB +: cktt_pkg::WIDX_BITS];
   assign to_site   = req_tdata[cktt_pkg::TO_LSB +: cktt_pkg::HSITE_BITS];
   assign from_site = req_tdata[cktt_pkg::FROM_LSB +: cktt_pkg::HSITE_BITS];
   assign spin      = req_tdata[cktt_pkg::SPIN_LSB];

   assign half     = cfg.sites >> 1;
   // spin 0 lands in the upper half of the sites
   assign offset   = spin ? {cktt_pkg::SCOUNT_BITS{1'b0}} : half;
   assign to_pos   = cktt_pkg::SCOUNT_BITS'(to_site) + offset;
   assign from_pos = cktt_pkg::SCOUNT_BITS'(from_site) + offset;
   assign hop_ok   = (cktt_pkg::SCOUNT_BITS'(to_site) < half)
                  && (cktt_pkg::SCOUNT_BITS'(from_site) < half);

   always_comb begin
      entry_in         = '0;
      entry_in.widx    = widx;
      entry_in.wval    = req_tdata[cktt_pkg::WVAL_LSB +: cktt_pkg::WEIGHT_BITS];
      entry_in.occ     = req_tdata[cktt_pkg::OCC_LSB +: cktt_pkg::OCC_BITS];
      entry_in.clr_pos = from_pos[cktt_pkg::SITE_BITS-1:0];
      entry_in.set_pos = to_pos[cktt_pkg::SITE_BITS-1:0];
      keep             = 1'b0;
      case (req_tuser)
         cktt_pkg::CMD_WEIGHT: begin
            entry_in.op = cktt_pkg::OP_WEIGHT;
            keep        = int'(widx) < MAX_TAPS;
         end
         cktt_pkg::CMD_LOAD: begin
            entry_in.op = cktt_pkg::OP_LOAD;
            keep        = 1'b1;
         end
         cktt_pkg::CMD_HOP: begin
            // out-of-range hop still refreshes the table
            entry_in.op = hop_ok ? cktt_pkg::OP_HOP : cktt_pkg::OP_REFRESH;
            keep        = 1'b1;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign req_tready = count_ff != QCW'(QD);
   assign push       = req_tvalid && req_tready && keep;
   assign job_valid  = count_ff != '0;
   assign pop        = job_valid && job_ready;
   assign job        = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPW'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QPW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= entry_in;
      end
   end

endmodule

// ===== hw/rtl/cktt_back.sv =====
// Sum engine: weight and occupancy state, tap index setup and the per-site adder pipeline.
module cktt_back #(
   parameter int MAX_SITES = cktt_pkg::MAX_SITES_DEF,
   parameter int MAX_TAPS  = cktt_pkg::MAX_TAPS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  cktt_pkg::cfg_type                  cfg,
   input  logic                               job_valid,
   output logic                               job_ready,
   input  cktt_pkg::job_type                  job,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // site_index, theta, zero pad
   output logic [cktt_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   output logic                               rsp_tlast
);

   localparam int SITE_W = $clog2(MAX_SITES);
   localparam int TAP_W  = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
   localparam int GROUPS = (MAX_TAPS + 3) / 4;
   localparam int PART_W = cktt_pkg::WEIGHT_BITS + 2;
   localparam int RAW_W  = cktt_pkg::WEIGHT_BITS + $clog2(MAX_TAPS + 1) + 1;
   localparam int SUM_W  = (RAW_W > cktt_pkg::THETA_BITS) ? RAW_W : cktt_pkg::THETA_BITS;
   localparam int PAD_W  = cktt_pkg::RSP_DATA_BITS - cktt_pkg::THETA_BITS
                         - cktt_pkg::SITE_BITS;
   localparam int SC_W   = cktt_pkg::SCOUNT_BITS;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_SETUP = 3'b010,
      ST_SWEEP = 3'b100
   } state_type;

   state_type                            state_ff, state_in;
   logic signed [cktt_pkg::WEIGHT_BITS-1:0] weights_ff [MAX_TAPS];
   logic signed [cktt_pkg::WEIGHT_BITS-1:0] weights_in [MAX_TAPS];
   logic [MAX_SITES-1:0]                 occ_ff, occ_in;
   logic [SITE_W-1:0]                    s_ff [MAX_TAPS];
   logic [SITE_W-1:0]                    s_in [MAX_TAPS];
   logic [SITE_W-1:0]                    run_ff, run_in;
   logic [TAP_W-1:0]                     tcnt_ff, tcnt_in;
   logic [SITE_W-1:0]                    j_ff, j_in;

   logic                                 pv_ff;
   logic [cktt_pkg::SITE_BITS-1:0]       psite_ff;
   logic                                 plast_ff;
   logic signed [PART_W-1:0]             part_ff [GROUPS];
   logic signed [PART_W-1:0]             part_in [GROUPS];
   logic [MAX_TAPS-1:0]                  tap_hit;

   logic                                 rsp_valid_ff;
   logic [cktt_pkg::SITE_BITS-1:0]       rsp_site_ff;
   logic [cktt_pkg::THETA_BITS-1:0]      rsp_theta_ff;
   logic                                 rsp_last_ff;
   logic signed [SUM_W-1:0]              sum_in;

   logic adv, issue, last_site;

   function automatic logic [SITE_W-1:0] next_site(input logic [SITE_W-1:0] s,
                                                  input logic [SC_W-1:0] n);
      logic [SC_W-1:0] w;
      w = SC_W'(s) + SC_W'(1);
      return (w == n) ? '0 : w[SITE_W-1:0];
   endfunction

   assign job_ready = state_ff == ST_IDLE;
   assign adv       = !rsp_valid_ff || rsp_tready;
   assign issue     = (state_ff == ST_SWEEP) && adv;
   assign last_site = (SC_W'(j_ff) + SC_W'(1)) == cfg.sites;

   always_comb begin
      state_in   = state_ff;
      weights_in = weights_ff;
      occ_in     = occ_ff;
      s_in       = s_ff;
      run_in     = run_ff;
      tcnt_in    = tcnt_ff;
      j_in       = j_ff;
      case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               case (job.op)
                  cktt_pkg::OP_WEIGHT: begin
                     for (int k = 0; k < MAX_TAPS; k++) begin
                        if (int'(job.widx) == k) begin
                           weights_in[k] = job.wval;
                        end
                     end
                  end
                  cktt_pkg::OP_LOAD: begin
                     occ_in = job.occ[MAX_SITES-1:0];
                  end
                  cktt_pkg::OP_HOP: begin
                     // clear first, so a hop onto its own site leaves it set
                     occ_in[job.clr_pos[SITE_W-1:0]] = 1'b0;
                     occ_in[job.set_pos[SITE_W-1:0]] = 1'b1;
                  end
                  default: begin
                  end
               endcase
               if (job.op != cktt_pkg::OP_WEIGHT) begin
                  state_in = ST_SETUP;
                  run_in   = '0;
                  tcnt_in  = '0;
               end
            end
         end
         ST_SETUP: begin
            // shift in k mod n; after MAX_TAPS steps tap k sits at site k mod n
            for (int k = 0; k < MAX_TAPS - 1; k++) begin
               s_in[k] = s_ff[k+1];
            end
            s_in[MAX_TAPS-1] = run_ff;
            run_in  = next_site(run_ff, cfg.sites);
            tcnt_in = tcnt_ff + TAP_W'(1);
            if (tcnt_ff == TAP_W'(MAX_TAPS - 1)) begin
               state_in = ST_SWEEP;
               j_in     = '0;
            end
         end
         ST_SWEEP: begin
            if (adv) begin
               for (int k = 0; k < MAX_TAPS; k++) begin
                  s_in[k] = next_site(s_ff[k], cfg.sites);
               end
               j_in = j_ff + SITE_W'(1);
               if (last_site) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // stage A: occupancy lookup per tap, partial sums in groups of four
   always_comb begin
      for (int k = 0; k < MAX_TAPS; k++) begin
         tap_hit[k] = occ_ff[s_ff[k]] && (k < int'(cfg.taps));
      end
      for (int g = 0; g < GROUPS; g++) begin
         part_in[g] = '0;
      end
      for (int k = 0; k < MAX_TAPS; k++) begin
         if (tap_hit[k]) begin
            part_in[k >> 2] = part_in[k >> 2] + PART_W'(weights_ff[k]);
         end
      end
   end

   // stage B: bias plus the group partials
   always_comb begin
      sum_in = SUM_W'(cfg.bias);
      for (int g = 0; g < GROUPS; g++) begin
         sum_in = sum_in + SUM_W'(part_ff[g]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         occ_ff       <= '0;
         run_ff       <= '0;
         tcnt_ff      <= '0;
         j_ff         <= '0;
         pv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         occ_ff   <= occ_in;
         run_ff   <= run_in;
         tcnt_ff  <= tcnt_in;
         j_ff     <= j_in;
         if (adv) begin
            pv_ff        <= issue;
            rsp_valid_ff <= pv_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      weights_ff <= weights_in;
      s_ff       <= s_in;
      if (adv) begin
         psite_ff     <= cktt_pkg::SITE_BITS'(j_ff);
         plast_ff     <= last_site;
         part_ff      <= part_in;
         rsp_site_ff  <= psite_ff;
         rsp_theta_ff <= sum_in[cktt_pkg::THETA_BITS-1:0];
         rsp_last_ff  <= plast_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, rsp_theta_ff, rsp_site_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== hw/rtl/circular_kernel_theta_table.sv =====
// Circular kernel theta table: top level with configuration registers, front and back.
//
// Each load or hop word refreshes the whole table and returns one word per site in
// site order, tlast on the final site; a weight write returns nothing. A refresh first
// lines up the per-tap site indices, then issues one site per cycle through a
// two-stage adder pipeline (all taps summed in parallel); rsp_tready low stalls the
// sweep. A two-word queue sits between decode and the engine, so the next words are
// taken while a sweep runs. Configuration writes are taken any cycle, but belong only
// to an idle block.
module circular_kernel_theta_table #(
   parameter int MAX_SITES = cktt_pkg::MAX_SITES_DEF,
   parameter int MAX_TAPS  = cktt_pkg::MAX_TAPS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // weight_index, weight_value, occupancy, spin, to_site, from_site, zero pad
   input  logic [cktt_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   // cmd
   input  logic [cktt_pkg::CMD_BITS-1:0]       req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // site_index, theta, zero pad
   output logic [cktt_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   output logic                                rsp_tlast,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [cktt_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [cktt_pkg::CSR_DATA_BITS-1:0]  csr_data
);

   logic [cktt_pkg::SCOUNT_BITS-1:0]      site_count_ff, site_count_in;
   logic [cktt_pkg::TCOUNT_BITS-1:0]      tap_count_ff, tap_count_in;
   logic signed [cktt_pkg::BIAS_BITS-1:0] bias_ff, bias_in;
   cktt_pkg::cfg_type                     cfg;
   logic                                  job_valid, job_ready;
   cktt_pkg::job_type                     job;

   assign csr_ready = 1'b1;

   always_comb begin
      site_count_in = site_count_ff;
      tap_count_in  = tap_count_ff;
      bias_in       = bias_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            cktt_pkg::CSR_SITE_COUNT: site_count_in = csr_data[cktt_pkg::SCOUNT_BITS-1:0];
            cktt_pkg::CSR_TAP_COUNT:  tap_count_in  = csr_data[cktt_pkg::TCOUNT_BITS-1:0];
            cktt_pkg::CSR_BIAS:       bias_in       = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         site_count_ff <= cktt_pkg::SITE_COUNT_RST;
         tap_count_ff  <= cktt_pkg::TAP_COUNT_RST;
         bias_ff       <= cktt_pkg::BIAS_RST;
      end else begin
         site_count_ff <= site_count_in;
         tap_count_ff  <= tap_count_in;
         bias_ff       <= bias_in;
      end
   end

   always_comb begin
      cfg.taps = tap_count_ff;
      cfg.bias = bias_ff;
      if (site_count_ff < cktt_pkg::SCOUNT_BITS'(cktt_pkg::MIN_SITES)) begin
         cfg.sites = cktt_pkg::SCOUNT_BITS'(cktt_pkg::MIN_SITES);
      end else if (site_count_ff > cktt_pkg::SCOUNT_BITS'(MAX_SITES)) begin
         cfg.sites = cktt_pkg::SCOUNT_BITS'(MAX_SITES);
      end else begin
         cfg.sites = site_count_ff;
      end
   end

   cktt_front #(
      .MAX_TAPS (MAX_TAPS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cfg        (cfg),
      .job_valid  (job_valid),
      .job_ready  (job_ready),
      .job        (job)
   );

   cktt_back #(
      .MAX_SITES (MAX_SITES),
      .MAX_TAPS  (MAX_TAPS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .job_valid  (job_valid),
      .job_ready  (job_ready),
      .job        (job),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== tb/sv/circular_kernel_theta_table_test.sv =====
// Self-checking testbench for the circular kernel theta table: random and directed commands.
module circular_kernel_theta_table_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [cktt_pkg::CMD_BITS-1:0] CMD_NOP = 2'd3;
   localparam int HOLD_CYCLES    = 400;
   localparam int SETTLE_CYCLES  = 200;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int PHASES         = 8;
   localparam int WORDS_PER_PHASE = 22;

   typedef struct {
      logic [cktt_pkg::CMD_BITS-1:0]           cmd;
      logic [cktt_pkg::WIDX_BITS-1:0]          widx;
      logic signed [cktt_pkg::WEIGHT_BITS-1:0] wval;
      logic [cktt_pkg::OCC_BITS-1:0]           occ;
      logic                                    spin;
      logic [cktt_pkg::HSITE_BITS-1:0]         to_site;
      logic [cktt_pkg::HSITE_BITS-1:0]         from_site;
   } lattice_word_type;

   typedef struct {
      logic [cktt_pkg::SITE_BITS-1:0]         site;
      logic signed [cktt_pkg::THETA_BITS-1:0] theta;
      logic                                   last;
   } theta_word_type;

   logic                                    clock = 1'b0;
   logic                                    reset = 1'b1;
   logic                                    req_tvalid = 1'b0;
   logic                                    req_tready;
   logic [cktt_pkg::REQ_DATA_BITS-1:0]      req_tdata = '0;
   logic [cktt_pkg::CMD_BITS-1:0]           req_tuser = '0;
   logic                                    rsp_tvalid;
   logic                                    rsp_tready = 1'b0;
   logic [cktt_pkg::RSP_DATA_BITS-1:0]      rsp_tdata;
   logic                                    rsp_tlast;
   logic                                    csr_valid = 1'b0;
   logic                                    csr_ready;
   logic [cktt_pkg::CSR_INDEX_BITS-1:0]     csr_index = '0;
   logic [cktt_pkg::CSR_DATA_BITS-1:0]      csr_data = '0;

   circular_kernel_theta_table uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   // shadow of the block's registers and tables
   logic [cktt_pkg::SCOUNT_BITS-1:0]        site_count_q = cktt_pkg::SITE_COUNT_RST;
   logic [cktt_pkg::TCOUNT_BITS-1:0]        tap_count_q  = cktt_pkg::TAP_COUNT_RST;
   logic signed [cktt_pkg::BIAS_BITS-1:0]   bias_q       = cktt_pkg::BIAS_RST;
   logic signed [cktt_pkg::WEIGHT_BITS-1:0] kernel_w [cktt_pkg::MAX_TAPS_DEF];
   logic [cktt_pkg::OCC_BITS-1:0]           occ_q = '0;

   lattice_word_type word_queue [$];
   theta_word_type   theta_due [$];
   lattice_word_type on_wire;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_asks = 0;
   int hold_done = 0;
   int hold_left = 0;
   int mismatches = 0;
   int quiet_cycles = 0;

   function automatic int sites_in_use(logic [cktt_pkg::SCOUNT_BITS-1:0] sc);
      if (sc < cktt_pkg::MIN_SITES) return cktt_pkg::MIN_SITES;
      if (sc > cktt_pkg::MAX_SITES_DEF) return cktt_pkg::MAX_SITES_DEF;
      return int'(sc);
   endfunction

   // applies one accepted word to the shadow state and queues the site sums it causes
   function automatic void apply_word(lattice_word_type w);
      int n, t, half, ts, fs, acc;
      theta_word_type r;
      if (w.cmd == cktt_pkg::CMD_WEIGHT) begin
         kernel_w[w.widx] = w.wval;
         return;
      end
      if (w.cmd != cktt_pkg::CMD_LOAD && w.cmd != cktt_pkg::CMD_HOP) return;
      n = sites_in_use(site_count_q);
      t = (tap_count_q > cktt_pkg::MAX_TAPS_DEF) ? cktt_pkg::MAX_TAPS_DEF
                                                 : int'(tap_count_q);
      half = n / 2;
      if (w.cmd == cktt_pkg::CMD_LOAD) begin
         occ_q = w.occ;
      end else if (w.to_site < half && w.from_site < half) begin
         ts = w.to_site;
         fs = w.from_site;
         if (!w.spin) begin
            ts += half;
            fs += half;
         end
         // clear first so a hop onto its own site leaves it occupied
         occ_q[fs] = 1'b0;
         occ_q[ts] = 1'b1;
      end
      for (int j = 0; j < n; j++) begin
         acc = bias_q;
         for (int k = 0; k < t; k++)
            if (occ_q[(j + k) % n]) acc += kernel_w[k];
         r.site = cktt_pkg::SITE_BITS'(j);
         r.theta = cktt_pkg::THETA_BITS'(acc);
         r.last = (j == n - 1);
         theta_due.push_back(r);
      end
   endfunction

   function automatic lattice_word_type mk_word(
         logic [cktt_pkg::CMD_BITS-1:0] cmd,
         logic [cktt_pkg::WIDX_BITS-1:0] widx,
         logic signed [cktt_pkg::WEIGHT_BITS-1:0] wval,
         logic [cktt_pkg::OCC_BITS-1:0] occ, logic spin,
         logic [cktt_pkg::HSITE_BITS-1:0] to_site,
         logic [cktt_pkg::HSITE_BITS-1:0] from_site);
      lattice_word_type w;
      w.cmd = cmd;
      w.widx = widx;
      w.wval = wval;
      w.occ = occ;
      w.spin = spin;
      w.to_site = to_site;
      w.from_site = from_site;
      return w;
   endfunction

   function automatic lattice_word_type random_word(int half);
      lattice_word_type w;
      int pick;
      w = mk_word(cktt_pkg::CMD_HOP, cktt_pkg::WIDX_BITS'($urandom),
                  cktt_pkg::WEIGHT_BITS'($urandom), {$urandom, $urandom}, 1'($urandom),
                  cktt_pkg::HSITE_BITS'($urandom), cktt_pkg::HSITE_BITS'($urandom));
      pick = $urandom_range(99);
      if (pick < 20) begin
         w.cmd = cktt_pkg::CMD_WEIGHT;
         case ($urandom_range(7))
            0: w.wval = 16'sh7FFF;
            1: w.wval = 16'sh8000;
            2: w.wval = '0;
            default: ;
         endcase
      end else if (pick < 45) begin
         w.cmd = cktt_pkg::CMD_LOAD;
         case ($urandom_range(9))
            0: w.occ = '0;
            1: w.occ = '1;
            2: w.occ = cktt_pkg::OCC_BITS'(1) << $urandom_range(63);
            default: ;
         endcase
      end else if (pick < 95) begin
         // mostly legal hops; the rest keep full 5-bit indices and may fall outside
         if ($urandom_range(6) != 0) begin
            w.to_site = cktt_pkg::HSITE_BITS'($urandom_range(half - 1));
            w.from_site = ($urandom_range(7) == 0) ? w.to_site :
                          cktt_pkg::HSITE_BITS'($urandom_range(half - 1));
         end
      end else begin
         w.cmd = CMD_NOP;
      end
      return w;
   endfunction

   task automatic write_csr(input logic [cktt_pkg::CSR_INDEX_BITS-1:0] idx,
                            input logic [cktt_pkg::CSR_DATA_BITS-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         cktt_pkg::CSR_SITE_COUNT: site_count_q = val[cktt_pkg::SCOUNT_BITS-1:0];
         cktt_pkg::CSR_TAP_COUNT:  tap_count_q = val[cktt_pkg::TCOUNT_BITS-1:0];
         cktt_pkg::CSR_BIAS:       bias_q = val;
         default: ;
      endcase
   endtask

   // wait for every queued word to go out and every site sum to come back
   task automatic drain();
      while (word_queue.size() != 0 || req_tvalid || theta_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // sender
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) apply_word(on_wire);
         if (!req_tvalid || req_tready) begin
            if (word_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               on_wire = word_queue.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= {1'b0, on_wire.from_site, on_wire.to_site, on_wire.spin,
                             on_wire.occ, on_wire.wval, on_wire.widx};
               req_tuser <= on_wire.cmd;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // receiver and checker
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (theta_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected word: site %0d theta %0d last %0b", rsp_tdata[5:0],
                           $signed(rsp_tdata[26:6]), rsp_tlast);
            end else begin
               theta_word_type exp_w;
               exp_w = theta_due.pop_front();
               if (rsp_tdata[5:0] !== exp_w.site || rsp_tdata[26:6] !== exp_w.theta ||
                   rsp_tlast !== exp_w.last) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected site %0d theta %0d last %0b, ",
                              exp_w.site, exp_w.theta, exp_w.last,
                              "got site %0d theta %0d last %0b", rsp_tdata[5:0],
                              $signed(rsp_tdata[26:6]), rsp_tlast);
               end
            end
         end
         if (hold_done != hold_asks) begin
            hold_done = hold_asks;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // watchdog on cycles with no word moving anywhere
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   initial begin
      int ph_sites [PHASES];
      int ph_taps [PHASES];
      int send_pct [4];
      int recv_pct [4];
      logic [cktt_pkg::BIAS_BITS-1:0] bias_val;
      lattice_word_type w;
      int made;

      ph_sites = '{8, 2, 0, 127, 33, 6, 16, 64};
      ph_taps = '{4, 1, 0, 31, 16, 12, 16, 16};
      send_pct = '{0, 68, 0, 13};
      recv_pct = '{0, 0, 68, 13};

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: fill every tap first, extremes among them, under the reset settings
      for (int k = 0; k < cktt_pkg::MAX_TAPS_DEF; k++) begin
         case (k)
            0: w = mk_word(cktt_pkg::CMD_WEIGHT, cktt_pkg::WIDX_BITS'(k), 16'sh7FFF, '0,
                           1'b0, '0, '0);
            1: w = mk_word(cktt_pkg::CMD_WEIGHT, cktt_pkg::WIDX_BITS'(k), 16'sh8000, '0,
                           1'b0, '0, '0);
            2: w = mk_word(cktt_pkg::CMD_WEIGHT, cktt_pkg::WIDX_BITS'(k), 16'sh0001, '0,
                           1'b0, '0, '0);
            3: w = mk_word(cktt_pkg::CMD_WEIGHT, cktt_pkg::WIDX_BITS'(k), -16'sh0001, '0,
                           1'b0, '0, '0);
            default: w = mk_word(cktt_pkg::CMD_WEIGHT, cktt_pkg::WIDX_BITS'(k),
                                 cktt_pkg::WEIGHT_BITS'($urandom), '0, 1'b0, '0, '0);
         endcase
         word_queue.push_back(w);
      end
      word_queue.push_back(mk_word(CMD_NOP, '1, '1, '1, 1'b1, '1, '1));
      word_queue.push_back(mk_word(cktt_pkg::CMD_LOAD, '0, '0, '0, 1'b0, '0, '0));
      word_queue.push_back(mk_word(cktt_pkg::CMD_LOAD, '0, '0, '1, 1'b0, '0, '0));
      word_queue.push_back(mk_word(cktt_pkg::CMD_LOAD, '0, '0, {16{4'hA}}, 1'b0, '0, '0));
      word_queue.push_back(mk_word(cktt_pkg::CMD_HOP, '0, '0, '0, 1'b1, 5'd31, 5'd0));
      word_queue.push_back(mk_word(cktt_pkg::CMD_HOP, '0, '0, '0, 1'b0, 5'd0, 5'd31));
      word_queue.push_back(mk_word(cktt_pkg::CMD_HOP, '0, '0, '0, 1'b1, 5'd5, 5'd5));
      word_queue.push_back(mk_word(cktt_pkg::CMD_HOP, '0, '0, '0, 1'b0, 5'd31, 5'd31));
      word_queue.push_back(mk_word(cktt_pkg::CMD_LOAD, '0, '0, {16{4'h5}}, 1'b0, '0, '0));
      drain();

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: bias_val = 16'h8000;
            1: bias_val = 16'h7FFF;
            2: bias_val = 16'h0000;
            7: bias_val = cktt_pkg::BIAS_RST;
            default: bias_val = cktt_pkg::BIAS_BITS'($urandom);
         endcase
         write_csr(cktt_pkg::CSR_SITE_COUNT, cktt_pkg::CSR_DATA_BITS'(ph_sites[p]));
         write_csr(cktt_pkg::CSR_TAP_COUNT, cktt_pkg::CSR_DATA_BITS'(ph_taps[p]));
         write_csr(cktt_pkg::CSR_BIAS, bias_val);
         send_idle_pct = send_pct[p % 4];
         recv_stall_pct = recv_pct[p % 4];
         // long receiver hold-off while the sender keeps pushing
         if (p == 4) hold_asks++;
         made = 0;
         while (made < WORDS_PER_PHASE) begin
            w = random_word(sites_in_use(site_count_q) / 2);
            word_queue.push_back(w);
            if (w.cmd != CMD_NOP) made++;
         end
         drain();
      end

      if (mismatches == 0 && theta_due.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
